// ===== hdl/blsc_pkg.sv =====
// ----------------------------------------------------------------------------
// blsc_pkg: shared types and constants of the line stepper
// Default coordinate width, color width, word modes and the per-line flags.
// ----------------------------------------------------------------------------
package blsc_pkg;

    // Default coordinate width and fixed color width
    localparam int COORD_BITS_DEF = 11;
    localparam int COLOR_BITS     = 32;

    // Word modes: load a new line or step the current one
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Per-line direction flags, fixed at load
    typedef struct packed {
        logic x_major;    // x is the axis that advances every pixel
        logic step_down;  // minor coordinate decreases when it moves
    } line_ctrl_t;

endpackage

// ===== hdl/bresenham_line_stepper_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core: Bresenham line rasterizer, one pixel per word
// Input words either load a line (mode 0) or request its next pixel (mode 1).
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready): mode plus two endpoints. A load word
//     starts a line and yields its first pixel; a step word yields the next
//     pixel. A step word with no line in progress is consumed with no output.
//   out channel (out_valid/out_ready): pixel_x, pixel_y, pixel_color and
//     last, set on the final pixel of a line.
//   cfg channel (cfg_valid/cfg_ready): cfg_data sets the pixel color; always
//     ready. The user must write it only while no word is in flight; the
//     block does not enforce this.
//   Path: the input word passes the input register, then the result
//     register, before out_valid rises. Throughput: one word per cycle while
//     the receiver does not stall, set by the single step unit between them.
//   Reset clears the busy flag, both valid flags and the color; the data
//     registers are always loaded before they are read.
//   When the receiver stalls, the result register holds; one more word waits
//   in the input register, after which in_ready drops.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core #(
    parameter int COORD_BITS = blsc_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [COORD_BITS-1:0]           start_x,
    input  logic [COORD_BITS-1:0]           start_y,
    input  logic [COORD_BITS-1:0]           end_x,
    input  logic [COORD_BITS-1:0]           end_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [COORD_BITS-1:0]           pixel_x,
    output logic [COORD_BITS-1:0]           pixel_y,
    output logic [blsc_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [blsc_pkg::COLOR_BITS-1:0] cfg_data
);
    import blsc_pkg::*;

    localparam int EW = COORD_BITS + 3;

    // Input register
    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [COORD_BITS-1:0] in_sx_reg;
    logic [COORD_BITS-1:0] in_sy_reg;
    logic [COORD_BITS-1:0] in_ex_reg;
    logic [COORD_BITS-1:0] in_ey_reg;

    // Line state
    logic                  busy_reg;
    logic                  busy_next;
    logic [COORD_BITS-1:0] cur_x_reg;
    logic [COORD_BITS-1:0] cur_y_reg;
    logic [COORD_BITS-1:0] major_end_reg;
    line_ctrl_t            ctrl_reg;
    logic signed [EW-1:0]  error_reg;
    logic signed [EW-1:0]  inc_move_reg;
    logic [COORD_BITS:0]   inc_stay_reg;

    // Color register
    logic [COLOR_BITS-1:0] color_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic [COLOR_BITS-1:0] pix_color_reg;
    logic                  pix_last_reg;

    // Setup and step signals
    logic                  is_load;
    logic                  advance;
    logic                  emit;
    logic [COORD_BITS-1:0] ld_x;
    logic [COORD_BITS-1:0] ld_y;
    logic [COORD_BITS-1:0] ld_major_end;
    line_ctrl_t            ld_ctrl;
    logic signed [EW-1:0]  ld_error;
    logic signed [EW-1:0]  ld_inc_move;
    logic [COORD_BITS:0]   ld_inc_stay;
    logic [COORD_BITS-1:0] sel_x;
    logic [COORD_BITS-1:0] sel_y;
    logic [COORD_BITS-1:0] sel_major_end;
    line_ctrl_t            sel_ctrl;
    logic signed [EW-1:0]  sel_error;
    logic signed [EW-1:0]  sel_inc_move;
    logic [COORD_BITS:0]   sel_inc_stay;
    logic                  st_last;
    logic [COORD_BITS-1:0] st_next_x;
    logic [COORD_BITS-1:0] st_next_y;
    logic signed [EW-1:0]  st_error_next;

    // Handshake: process the held word when the result slot is free or leaving
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign is_load   = (in_mode_reg == MODE_LOAD);
    assign emit      = advance && (is_load || busy_reg);

    blsc_load #(
        .COORD_BITS(COORD_BITS)
    ) u_load (
        .start_x   (in_sx_reg),
        .start_y   (in_sy_reg),
        .end_x     (in_ex_reg),
        .end_y     (in_ey_reg),
        .first_x   (ld_x),
        .first_y   (ld_y),
        .major_end (ld_major_end),
        .ctrl      (ld_ctrl),
        .error_init(ld_error),
        .inc_move  (ld_inc_move),
        .inc_stay  (ld_inc_stay)
    );

    // Pick fresh setup on load, held line state on step
    assign sel_x         = is_load ? ld_x         : cur_x_reg;
    assign sel_y         = is_load ? ld_y         : cur_y_reg;
    assign sel_major_end = is_load ? ld_major_end : major_end_reg;
    assign sel_ctrl      = is_load ? ld_ctrl      : ctrl_reg;
    assign sel_error     = is_load ? ld_error     : error_reg;
    assign sel_inc_move  = is_load ? ld_inc_move  : inc_move_reg;
    assign sel_inc_stay  = is_load ? ld_inc_stay  : inc_stay_reg;

    blsc_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .cur_x     (sel_x),
        .cur_y     (sel_y),
        .major_end (sel_major_end),
        .ctrl      (sel_ctrl),
        .error_cur (sel_error),
        .inc_move  (sel_inc_move),
        .inc_stay  (sel_inc_stay),
        .is_last   (st_last),
        .next_x    (st_next_x),
        .next_y    (st_next_y),
        .error_next(st_error_next)
    );

    assign busy_next = emit ? !st_last : busy_reg;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                color_reg <= cfg_data;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_mode_reg <= mode;
            in_sx_reg   <= start_x;
            in_sy_reg   <= start_y;
            in_ex_reg   <= end_x;
            in_ey_reg   <= end_y;
        end
    end

    // Advance the line and hold the result word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cur_x_reg     <= st_next_x;
            cur_y_reg     <= st_next_y;
            error_reg     <= st_error_next;
            major_end_reg <= sel_major_end;
            ctrl_reg      <= sel_ctrl;
            inc_move_reg  <= sel_inc_move;
            inc_stay_reg  <= sel_inc_stay;
            pix_x_reg     <= sel_x;
            pix_y_reg     <= sel_y;
            pix_color_reg <= color_reg;
            pix_last_reg  <= st_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_color = pix_color_reg;
    assign last        = pix_last_reg;

endmodule

// ===== hdl/blsc_load.sv =====
// ----------------------------------------------------------------------------
// blsc_load: line setup
// Orders the endpoints along the major axis and derives the deltas, the
// starting decision term and the two error increments of a new line.
// ----------------------------------------------------------------------------
module blsc_load #(
    parameter int COORD_BITS = blsc_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    output logic [COORD_BITS-1:0]        first_x,
    output logic [COORD_BITS-1:0]        first_y,
    output logic [COORD_BITS-1:0]        major_end,
    output blsc_pkg::line_ctrl_t         ctrl,
    output logic signed [COORD_BITS+2:0] error_init,
    output logic signed [COORD_BITS+2:0] inc_move,
    output logic [COORD_BITS:0]          inc_stay
);
    import blsc_pkg::*;

    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  x_major;
    logic                  swap;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] d_major;
    logic [COORD_BITS-1:0] d_minor;
    logic [COORD_BITS:0]   twice_major;
    logic [COORD_BITS:0]   twice_minor;

    // Absolute deltas; equal deltas and vertical lines run along y
    assign abs_dx  = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
    assign abs_dy  = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
    assign x_major = (start_x != end_x) && (abs_dy < abs_dx);

    // Swap endpoints so the major coordinate rises
    assign swap = x_major ? (start_x > end_x) : (start_y > end_y);
    assign sx   = swap ? end_x   : start_x;
    assign sy   = swap ? end_y   : start_y;
    assign ex   = swap ? start_x : end_x;
    assign ey   = swap ? start_y : end_y;

    assign d_major     = x_major ? abs_dx : abs_dy;
    assign d_minor     = x_major ? abs_dy : abs_dx;
    assign twice_major = {d_major, 1'b0};
    assign twice_minor = {d_minor, 1'b0};

    // Line setup results
    assign first_x        = sx;
    assign first_y        = sy;
    assign major_end      = x_major ? ex : ey;
    assign ctrl.x_major   = x_major;
    assign ctrl.step_down = x_major ? (ey < sy) : (ex < sx);
    assign error_init     = $signed({2'b00, twice_minor}) - $signed({3'b000, d_major});
    assign inc_move       = $signed({2'b00, twice_minor}) - $signed({2'b00, twice_major});
    assign inc_stay       = twice_minor;

endmodule

// ===== hdl/blsc_step.sv =====
// ----------------------------------------------------------------------------
// blsc_step: one Bresenham step
// Flags the final pixel and computes the next position and decision term.
// ----------------------------------------------------------------------------
module blsc_step #(
    parameter int COORD_BITS = blsc_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]        cur_x,
    input  logic [COORD_BITS-1:0]        cur_y,
    input  logic [COORD_BITS-1:0]        major_end,
    input  blsc_pkg::line_ctrl_t         ctrl,
    input  logic signed [COORD_BITS+2:0] error_cur,
    input  logic signed [COORD_BITS+2:0] inc_move,
    input  logic [COORD_BITS:0]          inc_stay,
    output logic                         is_last,
    output logic [COORD_BITS-1:0]        next_x,
    output logic [COORD_BITS-1:0]        next_y,
    output logic signed [COORD_BITS+2:0] error_next
);
    import blsc_pkg::*;

    logic                  move_minor;
    logic [COORD_BITS-1:0] major_cur;
    logic [COORD_BITS-1:0] minor_cur;
    logic [COORD_BITS-1:0] major_adv;
    logic [COORD_BITS-1:0] minor_adv;
    logic signed [COORD_BITS+2:0] inc_sel;

    assign major_cur  = ctrl.x_major ? cur_x : cur_y;
    assign minor_cur  = ctrl.x_major ? cur_y : cur_x;
    assign is_last    = (major_cur == major_end);
    assign move_minor = (error_cur > 0);

    // Advance major by one, minor by one when the decision term is positive
    assign major_adv = major_cur + 1'b1;
    always_comb
    begin
        if (!move_minor)
            minor_adv = minor_cur;
        else if (ctrl.step_down)
            minor_adv = minor_cur - 1'b1;
        else
            minor_adv = minor_cur + 1'b1;
    end

    assign next_x = ctrl.x_major ? major_adv : minor_adv;
    assign next_y = ctrl.x_major ? minor_adv : major_adv;

    // Update the decision term
    assign inc_sel    = move_minor ? inc_move : $signed({2'b00, inc_stay});
    assign error_next = error_cur + inc_sel;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Bresenham line stepper
// Drives load and step words with random gaps, stalls the pixel side at
// random and checks every pixel against a line predictor kept in a small
// scoreboard class. The pixel color is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
    import blsc_pkg::*;

    localparam int   CW            = COORD_BITS_DEF;
    localparam int   COORD_MAX     = (1 << CW) - 1;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   HOLD_CYCLES   = 200;
    localparam int   PHASE_PIXELS  = 100;

    typedef logic [CW-1:0]         coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    // Line predictor and store of expected pixels
    class line_pixel_model;
        color_t     color;
        bit         drawing;
        coord_t     cur_x;
        coord_t     cur_y;
        coord_t     major_end;
        line_ctrl_t ctrl;
        int         err;
        int         twice_major;
        int         twice_minor;
        pixel_t     expected_pixels[$];
        int         errors;

        function new();
            color       = '0;
            drawing     = 1'b0;
            cur_x       = '0;
            cur_y       = '0;
            major_end   = '0;
            ctrl        = '0;
            err         = 0;
            twice_major = 0;
            twice_minor = 0;
            errors      = 0;
        endfunction

        // Latch endpoints in ascending major order and seed the error term
        function void load_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            int x0;
            int y0;
            int x1;
            int y1;
            int t;
            int adx;
            int ady;
            int dmaj;
            int dmin;
            x0 = int'(sx);
            y0 = int'(sy);
            x1 = int'(ex);
            y1 = int'(ey);
            adx = (x0 > x1) ? x0 - x1 : x1 - x0;
            ady = (y0 > y1) ? y0 - y1 : y1 - y0;
            // equal deltas go y-major
            ctrl.x_major = (x0 != x1) && (ady < adx);
            if (ctrl.x_major)
            begin
                if (x0 > x1)
                begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dmaj = adx;
                dmin = ady;
                ctrl.step_down = (y1 < y0);
                major_end = coord_t'(x1);
            end
            else
            begin
                if (y0 > y1)
                begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dmaj = ady;
                dmin = adx;
                ctrl.step_down = (x1 < x0);
                major_end = coord_t'(y1);
            end
            cur_x       = coord_t'(x0);
            cur_y       = coord_t'(y0);
            twice_major = 2 * dmaj;
            twice_minor = 2 * dmin;
            err         = 2 * dmin - dmaj;
        endfunction

        // Emit the current pixel, then advance one step along the major axis
        function void emit_pixel();
            coord_t major;
            logic   fin;
            major = ctrl.x_major ? cur_x : cur_y;
            fin = (major == major_end);
            expected_pixels.push_back('{cur_x, cur_y, color, fin});
            drawing = !fin;
            if (fin)
                return;
            if (err > 0)
            begin
                if (ctrl.x_major)
                    cur_y = ctrl.step_down ? cur_y - 1'b1 : cur_y + 1'b1;
                else
                    cur_x = ctrl.step_down ? cur_x - 1'b1 : cur_x + 1'b1;
                err -= twice_major;
            end
            err += twice_minor;
            if (ctrl.x_major)
                cur_x = cur_x + 1'b1;
            else
                cur_y = cur_y + 1'b1;
        endfunction

        // Note an accepted word; return 1 when it yields a pixel
        function bit note_word(logic m, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            if (m == MODE_LOAD)
                load_line(sx, sy, ex, ey);
            else if (!drawing)
                return 1'b0;
            emit_pixel();
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // Check one accepted pixel against the oldest expectation
        function void check_pixel(coord_t x, coord_t y, color_t c, logic l);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel (%0d,%0d) with none expected, expected nothing, actual 0x%0h",
                         $time, x, y, c);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pixel_x", 64'(want.x), 64'(x));
            compare_field("pixel_y", 64'(want.y), 64'(y));
            compare_field("pixel_color", 64'(want.color), 64'(c));
            compare_field("last", 64'(want.last), 64'(l));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid;
    logic   in_ready;
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   out_valid;
    logic   out_ready;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;
    logic   cfg_valid;
    logic   cfg_ready;
    color_t cfg_data;

    line_pixel_model model;
    bit              steady = 1'b0;
    bit              hold_request = 1'b0;
    int              pixels_sent = 0;

    bresenham_line_stepper_core #(
        .COORD_BITS (CW)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(logic m, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (model.note_word(m, sx, sy, ex, ey))
            pixels_sent++;
    endtask

    // Step words carry random endpoints that the block ignores
    task automatic step_words(int n);
        repeat (n)
            send_word(MODE_STEP, coord_t'($urandom_range(0, COORD_MAX)),
                      coord_t'($urandom_range(0, COORD_MAX)),
                      coord_t'($urandom_range(0, COORD_MAX)),
                      coord_t'($urandom_range(0, COORD_MAX)));
    endtask

    task automatic draw(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int n);
        send_word(MODE_LOAD, sx, sy, ex, ey);
        step_words(n);
    endtask

    // Drop valid, wait for every pending pixel, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        while (model.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_color(color_t v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model.color = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic int span(coord_t a, coord_t b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Endpoint at distance d from c, kept inside the coordinate range
    function automatic coord_t near(coord_t c, int d);
        int ci;
        ci = int'(c);
        if (($urandom_range(0, 1) == 1 && ci + d <= COORD_MAX) || ci < d)
            return coord_t'(ci + d);
        return coord_t'(ci - d);
    endfunction

    // One random line: mostly short and drawn to the end, some abandoned
    // early, some stepped past the end; a few stray words in between
    task automatic random_sequence();
        int     pick;
        int     dx;
        int     dy;
        int     len;
        int     n;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        pick = $urandom_range(0, 99);
        sx = coord_t'($urandom_range(0, COORD_MAX));
        sy = coord_t'($urandom_range(0, COORD_MAX));
        ex = coord_t'($urandom_range(0, COORD_MAX));
        ey = coord_t'($urandom_range(0, COORD_MAX));
        if (pick < 8)
        begin
            send_word($urandom_range(0, 1) ? MODE_STEP : MODE_LOAD, sx, sy, ex, ey);
            return;
        end
        if (pick >= 18)
        begin
            dx = $urandom_range(0, 12);
            dy = $urandom_range(0, 12);
            case ($urandom_range(0, 5))
                0: dx = 0;
                1: dy = 0;
                2: dy = dx;
                default: ;
            endcase
            ex = near(sx, dx);
            ey = near(sy, dy);
        end
        dx = span(sx, ex);
        dy = span(sy, ey);
        len = (dx > dy) ? dx : dy;
        pick = $urandom_range(0, 99);
        if (pick < 15 || len > 40)
            n = $urandom_range(0, (len < 12) ? len : 12);
        else if (pick < 30)
            n = len + $urandom_range(1, 2);
        else
            n = len;
        draw(sx, sy, ex, ey, n);
    endtask

    // Pixel side: random stalls, one long hold-off on request
    initial
    begin : pixel_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            model.check_pixel(pixel_x, pixel_y, pixel_color, last);
        end
    end

    initial
    begin : stimulus
        int ph;
        int base;
        model = new();
        in_valid  = 1'b0;
        mode      = MODE_LOAD;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines at the reset color
        step_words(1);                  // step with no line loaded
        draw(5, 5, 5, 5, 1);            // single point, then a stray step
        draw(3, 10, 3, 6, 4);           // vertical, drawn upward
        draw(2047, 0, 2044, 0, 3);      // horizontal, endpoints swapped
        draw(0, 2047, 3, 2044, 3);      // equal deltas
        draw(0, 10, 4, 9, 4);           // shallow, minor steps down
        draw(0, 0, 2047, 2047, 1);      // full span, abandoned by next load
        draw(2047, 0, 0, 2047, 1);

        // Change the color mid-line; later pixels carry the new one
        set_color('1);
        step_words(2);

        // Random phases, one color each
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_color('0);
                2: set_color(32'h8000_0001);
                default: set_color(color_t'($urandom));
            endcase
            steady = (ph == 2);
            if (ph == 3)
            begin
                // keep offering words while the pixel side holds off
                hold_request = 1'b1;
                steady = 1'b1;
                draw(100, 5, 140, 1900, 40);
                steady = 1'b0;
            end
            base = pixels_sent;
            while (pixels_sent - base < PHASE_PIXELS)
                random_sequence();
        end
        steady = 1'b0;

        settle();
        if (model.errors == 0 && model.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== bresenham_line_stepper_core.f =====
hdl/blsc_pkg.sv
hdl/blsc_load.sv
hdl/blsc_step.sv
hdl/bresenham_line_stepper_core.sv
sim/testbench.sv
